>>> hw/rtl/plwe_pkg.sv
// plwe_pkg: shared types and constants for the piecewise linear evaluator
// holds the controller/datapath command and status structs and result codes
// no dependencies
package plwe_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned AddrWidth  = $clog2(TableDepth);
  localparam int unsigned CountWidth = AddrWidth + 1;
  localparam int unsigned DataWidth  = 32;

  // case_taken codes
  localparam logic [1:0] CASE_EXACT  = 2'd0;
  localparam logic [1:0] CASE_BELOW  = 2'd1;
  localparam logic [1:0] CASE_ABOVE  = 2'd2;
  localparam logic [1:0] CASE_INTERP = 2'd3;

  // req_type codes
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_EVAL = 1'b1;

  typedef struct packed {
    logic load_wr;      // write one breakpoint
    logic eval_start;   // latch query, set up search bounds
    logic rd_mid;       // read table at the search midpoint
    logic srch_upd;     // narrow search bounds from read data
    logic rd_top;       // read the upper bracket entry
    logic chk;          // classify the query against the upper entry
    logic lo_cap;       // lower bracket entry is on the read port
    logic mul;          // form the product
    logic div_start;    // launch the divider
    logic emit_interp;  // write the interpolated result
  } plwe_cmd_t;

  typedef struct packed {
    logic lo_lt_hi;     // search not yet converged
    logic direct;       // result comes straight from the table
    logic div_done;     // quotient ready
  } plwe_status_t;

endpackage

>>> hw/rtl/plwe_divider.sv
// plwe_divider: restoring divider, 64-bit dividend by 32-bit divisor, one bit a cycle
// the quotient must fit 32 bits (upper half of dividend below divisor)
// depends on plwe_pkg
module plwe_divider
  import plwe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [2*DataWidth-1:0] dividend,
  input  logic [DataWidth-1:0] divisor,
  output logic [DataWidth-1:0] quotient,
  output logic                 done
);

  localparam int unsigned StepWidth = $clog2(DataWidth);

  logic                 active;
  logic [StepWidth-1:0] step;
  logic [DataWidth-1:0] rem;
  logic [DataWidth-1:0] low;
  logic [DataWidth:0]   trial;
  logic [DataWidth:0]   diff;
  logic                 qbit;

  always_comb begin
    trial = {rem, low[DataWidth-1]};
    diff  = trial - {1'b0, divisor};
    qbit  = (trial >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      step   <= '0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        step   <= '0;
      end else if (active) begin
        step <= step + 1'b1;
        if (step == StepWidth'(DataWidth - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift into low as dividend bits shift out
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[2*DataWidth-1:DataWidth];
      low <= dividend[DataWidth-1:0];
    end else if (active) begin
      rem <= qbit ? diff[DataWidth-1:0] : trial[DataWidth-1:0];
      low <= {low[DataWidth-2:0], qbit};
    end
  end

  assign quotient = low;

endmodule

>>> hw/rtl/plwe_datapath.sv
// plwe_datapath: breakpoint tables, search bounds, multiplier and result registers
// also holds the points_in_use register; driven by plwe_ctrl commands
// depends on plwe_pkg and plwe_divider
module plwe_datapath
  import plwe_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  plwe_cmd_t                   cmd,
  output plwe_status_t                status,
  input  logic [AddrWidth-1:0]        point_index,
  input  logic signed [DataWidth-1:0] x_value,
  input  logic signed [DataWidth-1:0] y_value,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CountWidth-1:0]       cfg_data,
  output logic                        result_valid,
  output logic signed [DataWidth-1:0] y_result,
  output logic [1:0]                  case_taken
);

  logic [DataWidth-1:0] x_mem [TableDepth];
  logic [DataWidth-1:0] y_mem [TableDepth];

  logic [CountWidth-1:0]       points_in_use;
  logic [CountWidth-1:0]       count_clamped;
  logic [CountWidth-1:0]       n;
  logic [CountWidth-1:0]       lo;
  logic [CountWidth-1:0]       hi;
  logic [CountWidth:0]         mid_sum;
  logic [AddrWidth-1:0]        mid;
  logic signed [DataWidth-1:0] x_q;

  logic                        rd_en;
  logic [AddrWidth-1:0]        rd_addr;
  logic signed [DataWidth-1:0] x_rd;
  logic signed [DataWidth-1:0] y_rd;

  logic signed [DataWidth-1:0] x1;
  logic signed [DataWidth-1:0] y1;
  logic signed [DataWidth-1:0] y0;
  logic [DataWidth-1:0]        dn;
  logic [DataWidth-1:0]        dy_mag;
  logic [DataWidth-1:0]        dx;
  logic                        neg;
  logic [2*DataWidth-1:0]      prod;

  logic signed [DataWidth:0]   dn_full;
  logic signed [DataWidth:0]   dy_full;
  logic signed [DataWidth:0]   dx_full;
  logic [DataWidth-1:0]        quotient;
  logic                        div_done;
  logic signed [DataWidth+1:0] res_full;
  logic signed [DataWidth-1:0] res_sat;

  logic above;
  logic exact;
  logic below;
  logic [1:0] direct_case;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      points_in_use <= CountWidth'(1);
    end else if (cfg_valid && cfg_ready) begin
      points_in_use <= cfg_data;
    end
  end

  always_comb begin
    if (points_in_use == '0) begin
      count_clamped = CountWidth'(1);
    end else if (points_in_use > CountWidth'(TableDepth)) begin
      count_clamped = CountWidth'(TableDepth);
    end else begin
      count_clamped = points_in_use;
    end
  end

  always_comb begin
    mid_sum = {1'b0, lo} + {1'b0, hi};
    mid     = mid_sum[AddrWidth:1];
  end

  // classification of the upper bracket entry
  always_comb begin
    above = (lo >= n);
    exact = !above && (x_rd == x_q);
    below = !above && !exact && (lo == '0);
    priority if (exact) begin
      direct_case = CASE_EXACT;
    end else if (above) begin
      direct_case = CASE_ABOVE;
    end else begin
      direct_case = CASE_BELOW;
    end
  end

  assign status.lo_lt_hi = (lo < hi);
  assign status.direct   = exact || above || below;
  assign status.div_done = div_done;

  // read address: midpoint, upper bracket (last entry when past the end), lower bracket
  always_comb begin
    rd_en   = cmd.rd_mid || cmd.rd_top || (cmd.chk && !status.direct);
    rd_addr = mid;
    priority if (cmd.rd_top) begin
      rd_addr = (lo >= n) ? AddrWidth'(n - 1'b1) : lo[AddrWidth-1:0];
    end else if (cmd.chk) begin
      rd_addr = AddrWidth'(lo - 1'b1);
    end else begin
      rd_addr = mid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      x_mem[point_index] <= x_value;
      y_mem[point_index] <= y_value;
    end
    if (rd_en) begin
      x_rd <= x_mem[rd_addr];
      y_rd <= y_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n  <= CountWidth'(1);
      lo <= '0;
      hi <= '0;
    end else if (cmd.eval_start) begin
      n  <= count_clamped;
      lo <= '0;
      hi <= count_clamped;
    end else if (cmd.srch_upd) begin
      if (x_rd < x_q) begin
        lo <= CountWidth'(mid) + 1'b1;
      end else begin
        hi <= CountWidth'(mid);
      end
    end
  end

  // on a table sorted by x the search leaves x0 < x < x1, so dn and dx are positive and q stays below |dy|
  always_comb begin
    dn_full = {x_q[DataWidth-1], x_q} - {x_rd[DataWidth-1], x_rd};
    dy_full = {y1[DataWidth-1], y1} - {y_rd[DataWidth-1], y_rd};
    dx_full = {x1[DataWidth-1], x1} - {x_rd[DataWidth-1], x_rd};
  end

  always_ff @(posedge clk) begin
    if (cmd.eval_start) begin
      x_q <= x_value;
    end
    if (cmd.chk) begin
      x1 <= x_rd;
      y1 <= y_rd;
    end
    if (cmd.lo_cap) begin
      y0     <= y_rd;
      dn     <= dn_full[DataWidth-1:0];
      dx     <= dx_full[DataWidth-1:0];
      neg    <= dy_full[DataWidth];
      dy_mag <= dy_full[DataWidth] ? DataWidth'(-dy_full) : dy_full[DataWidth-1:0];
    end
    if (cmd.mul) begin
      prod <= dn * dy_mag;
    end
  end

  plwe_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod),
    .divisor  (dx),
    .quotient (quotient),
    .done     (div_done)
  );

  always_comb begin
    if (neg) begin
      res_full = {{2{y0[DataWidth-1]}}, y0} - {2'b00, quotient};
    end else begin
      res_full = {{2{y0[DataWidth-1]}}, y0} + {2'b00, quotient};
    end
    if (res_full[DataWidth+1:DataWidth-1] == 3'b000 ||
        res_full[DataWidth+1:DataWidth-1] == 3'b111) begin
      res_sat = res_full[DataWidth-1:0];
    end else if (res_full[DataWidth+1]) begin
      res_sat = {1'b1, {(DataWidth-1){1'b0}}};
    end else begin
      res_sat = {1'b0, {(DataWidth-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (cmd.chk && status.direct) || cmd.emit_interp;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.chk && status.direct) begin
      y_result   <= y_rd;
      case_taken <= direct_case;
    end else if (cmd.emit_interp) begin
      y_result   <= res_sat;
      case_taken <= CASE_INTERP;
    end
  end

endmodule

>>> hw/rtl/plwe_ctrl.sv
// plwe_ctrl: sequencer for load and evaluate items
// steps the search, bracket fetch, multiply and divide in the datapath
// depends on plwe_pkg
module plwe_ctrl
  import plwe_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic         req_type,
  output logic         busy,
  input  plwe_status_t status,
  output plwe_cmd_t    cmd
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_SRCH = 8'b0000_0010,
    S_CMP  = 8'b0000_0100,
    S_CHK  = 8'b0000_1000,
    S_LO   = 8'b0001_0000,
    S_MUL  = 8'b0010_0000,
    S_DIVS = 8'b0100_0000,
    S_DIVW = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start && req_type == REQ_EVAL) begin
          cmd.eval_start = 1'b1;
          state_next     = S_SRCH;
        end else if (start) begin
          cmd.load_wr = 1'b1;
        end
      end
      S_SRCH: begin
        if (status.lo_lt_hi) begin
          cmd.rd_mid = 1'b1;
          state_next = S_CMP;
        end else begin
          cmd.rd_top = 1'b1;
          state_next = S_CHK;
        end
      end
      S_CMP: begin
        cmd.srch_upd = 1'b1;
        state_next   = S_SRCH;
      end
      S_CHK: begin
        cmd.chk    = 1'b1;
        state_next = status.direct ? S_IDLE : S_LO;
      end
      S_LO: begin
        cmd.lo_cap = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DIVS;
      end
      S_DIVS: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIVW;
      end
      S_DIVW: begin
        if (status.div_done) begin
          cmd.emit_interp = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

>>> hw/rtl/piecewise_linear_evaluator_unit.sv
// piecewise_linear_evaluator_unit: breakpoint table with binary search and linear interpolation
// a load item is written when accepted and leaves busy low; an evaluate item with at most
// s = ceil(log2(n+1)) search steps (s <= 7) reads the upper bracket and returns a table entry,
// or reads the lower bracket, multiplies and divides in the one-bit-a-cycle divider to interpolate
// one item at a time; results are strobed for one cycle and cannot be held off
// synchronous reset sets points_in_use to 1 and idles; table contents are undefined until loaded
module piecewise_linear_evaluator_unit
  import plwe_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        req_type,
  input  logic [AddrWidth-1:0]        point_index,
  input  logic signed [DataWidth-1:0] x_value,
  input  logic signed [DataWidth-1:0] y_value,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CountWidth-1:0]       cfg_data,
  output logic                        result_valid,
  output logic signed [DataWidth-1:0] y_result,
  output logic [1:0]                  case_taken
);

  plwe_cmd_t    cmd;
  plwe_status_t status;

  plwe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .busy     (busy),
    .status   (status),
    .cmd      (cmd)
  );

  plwe_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .point_index  (point_index),
    .x_value      (x_value),
    .y_value      (y_value),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .y_result     (y_result),
    .case_taken   (case_taken)
  );

endmodule

>>> dv/piecewise_linear_evaluator_unit_test.sv
`timescale 1ns / 100ps
// piecewise_linear_evaluator_unit_test: self-checking bench for the breakpoint table lookup
// loads tables, evaluates queries and checks each result against an interpolation predictor
// depends on plwe_pkg and piecewise_linear_evaluator_unit
module piecewise_linear_evaluator_unit_test;
  import plwe_pkg::*;

  localparam int DRAIN_CYCLES = 64;
  localparam int TAIL_ITEMS   = 150;
  localparam int TOTAL_ITEMS  = 1625;
  localparam int TIMEOUT_NS   = 10_000_000;
  localparam int MAX_REPORTS  = 10;

  typedef enum logic {CMD_ITEM, CMD_CFG} cmd_kind_t;
  typedef enum logic [1:0] {DRIVE_IDLE, DRIVE_ITEM, DRIVE_CFG} drive_state_t;

  typedef struct {
    cmd_kind_t              kind;
    logic                   req;
    logic [AddrWidth-1:0]   slot;
    logic signed [31:0]     xv;
    logic signed [31:0]     yv;
    logic [CountWidth-1:0]  count;
  } cmd_t;

  typedef struct {
    logic signed [31:0] qx;
    logic signed [31:0] y;
    logic [1:0]         code;
  } lookup_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        start = 1'b0;
  logic                        busy;
  logic                        req_type = REQ_LOAD;
  logic [AddrWidth-1:0]        point_index = '0;
  logic signed [DataWidth-1:0] x_value = '0;
  logic signed [DataWidth-1:0] y_value = '0;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CountWidth-1:0]       cfg_data = '0;
  logic                        result_valid;
  logic signed [DataWidth-1:0] y_result;
  logic [1:0]                  case_taken;

  cmd_t         cmd_queue[$];
  lookup_t      pending_lookups[$];
  drive_state_t drive_state = DRIVE_IDLE;
  int           items_taken = 0;
  int           items_seen = 0;
  int           cfg_taken = 0;
  int           cfg_seen = 0;
  int           quiet_cycles = 0;
  int           gap_left = 0;
  bit           idling_on = 1'b1;
  int           err_count = 0;
  int           item_count = 0;

  // predictor copy of the block state
  logic signed [31:0]    bp_x [TableDepth];
  logic signed [31:0]    bp_y [TableDepth];
  logic [CountWidth-1:0] bp_count = CountWidth'(1);

  // generator view of the table, used to aim queries
  logic signed [31:0] gen_x [TableDepth];

  piecewise_linear_evaluator_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .point_index  (point_index),
    .x_value      (x_value),
    .y_value      (y_value),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .y_result     (y_result),
    .case_taken   (case_taken)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic lookup_t lookup_breakpoint(input logic signed [31:0] xq);
    lookup_t r;
    int n, lo, hi, mid;
    longint x0, x1, y0, y1, dx, dn, dy, res;
    longint unsigned mdn, mdy, prod, q;
    r.qx = xq;
    n = bp_count;
    if (n < 1) n = 1;
    if (n > TableDepth) n = TableDepth;
    lo = 0;
    hi = n;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      if (bp_x[mid] < xq) lo = mid + 1;
      else hi = mid;
    end
    if (lo < n && bp_x[lo] == xq) begin
      r.y = bp_y[lo];
      r.code = CASE_EXACT;
    end else if (lo >= n) begin
      r.y = bp_y[n-1];
      r.code = CASE_ABOVE;
    end else if (lo == 0) begin
      r.y = bp_y[0];
      r.code = CASE_BELOW;
    end else begin
      x0 = bp_x[lo-1];
      x1 = bp_x[lo];
      y0 = bp_y[lo-1];
      y1 = bp_y[lo];
      dx = x1 - x0;
      if (dx <= 0) begin
        res = y0;
      end else begin
        dn = xq - x0;
        dy = y1 - y0;
        mdn = (dn < 0) ? -dn : dn;
        mdy = (dy < 0) ? -dy : dy;
        prod = mdn * mdy;
        q = prod / longint'(dx);
        if (q > 64'h1_FFFF_FFFF) q = 64'h1_FFFF_FFFF;
        if ((dn < 0) != (dy < 0)) res = y0 - longint'(q);
        else res = y0 + longint'(q);
      end
      if (res > 64'sd2147483647) res = 64'sd2147483647;
      if (res < -64'sd2147483648) res = -64'sd2147483648;
      r.y = res[31:0];
      r.code = CASE_INTERP;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] rand_between(input longint a, input longint b);
    longint unsigned span, r;
    if (b <= a) return a[31:0];
    span = b - a + 1;
    r = {$urandom(), $urandom()} % span;
    return 32'(a + longint'(r));
  endfunction

  task automatic push_load(input int slot, input logic signed [31:0] xv,
                           input logic signed [31:0] yv);
    cmd_t c;
    c.kind = CMD_ITEM;
    c.req = REQ_LOAD;
    c.slot = AddrWidth'(slot);
    c.xv = xv;
    c.yv = yv;
    c.count = '0;
    gen_x[slot] = xv;
    cmd_queue.insert(cmd_queue.size(), c);
    item_count++;
  endtask

  task automatic push_eval(input logic signed [31:0] xv);
    cmd_t c;
    c.kind = CMD_ITEM;
    c.req = REQ_EVAL;
    // slot and y are don't-care on an evaluate
    c.slot = AddrWidth'($urandom_range(0, TableDepth - 1));
    c.xv = xv;
    c.yv = $urandom();
    c.count = '0;
    cmd_queue.insert(cmd_queue.size(), c);
    item_count++;
  endtask

  task automatic push_cfg(input int v);
    cmd_t c;
    c.kind = CMD_CFG;
    c.req = REQ_LOAD;
    c.slot = '0;
    c.xv = '0;
    c.yv = '0;
    c.count = CountWidth'(v);
    cmd_queue.insert(cmd_queue.size(), c);
  endtask

  // driver: one item or one register write presented at a time
  always @(negedge clk) begin : drive_cmds
    cmd_t c;
    logic nxt_start, nxt_cfg_valid;
    if (rst) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      nxt_start = start;
      nxt_cfg_valid = cfg_valid;
      if (drive_state == DRIVE_ITEM && items_taken != items_seen) begin
        items_seen = items_taken;
        drive_state = DRIVE_IDLE;
        nxt_start = 1'b0;
      end
      if (drive_state == DRIVE_CFG && cfg_taken != cfg_seen) begin
        cfg_seen = cfg_taken;
        drive_state = DRIVE_IDLE;
        nxt_cfg_valid = 1'b0;
      end
      if (drive_state == DRIVE_IDLE) begin
        if (gap_left != 0) begin
          gap_left--;
          // junk on the fields while start is low
          req_type <= 1'($urandom_range(0, 1));
          point_index <= AddrWidth'($urandom_range(0, TableDepth - 1));
          x_value <= $urandom();
          y_value <= $urandom();
        end else if (cmd_queue.size() != 0) begin
          if (cmd_queue[0].kind == CMD_CFG) begin
            // register writes only once the block has gone quiet
            if (quiet_cycles >= DRAIN_CYCLES) begin
              c = cmd_queue.pop_front();
              cfg_data <= c.count;
              nxt_cfg_valid = 1'b1;
              drive_state = DRIVE_CFG;
            end
          end else begin
            c = cmd_queue.pop_front();
            req_type <= c.req;
            point_index <= c.slot;
            x_value <= c.xv;
            y_value <= c.yv;
            nxt_start = 1'b1;
            drive_state = DRIVE_ITEM;
            if ($urandom_range(0, 39) == 0) idling_on = !idling_on;
            if (idling_on && cmd_queue.size() > TAIL_ITEMS && $urandom_range(0, 2) == 0)
              gap_left = $urandom_range(1, 6);
          end
        end
      end
      start <= nxt_start;
      cfg_valid <= nxt_cfg_valid;
    end
  end

  // monitor: checks results first, then records the item taken at this edge
  always @(posedge clk) begin : check_results
    lookup_t exp_r;
    bit item_now;
    if (rst) begin
      bp_count = CountWidth'(1);
      quiet_cycles = 0;
    end else begin
      if (result_valid) begin
        if (pending_lookups.size() == 0) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("unexpected result: y=%0d case=%0d", y_result, case_taken);
        end else begin
          exp_r = pending_lookups.pop_front();
          if (y_result !== exp_r.y || case_taken !== exp_r.code) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
              $display("mismatch at x=%0d: y exp %0d got %0d, case exp %0d got %0d",
                       exp_r.qx, exp_r.y, y_result, exp_r.code, case_taken);
          end
        end
      end
      item_now = start && !busy;
      if (item_now) begin
        items_taken++;
        if (req_type == REQ_LOAD) begin
          bp_x[point_index] = x_value;
          bp_y[point_index] = y_value;
        end else begin
          pending_lookups.insert(pending_lookups.size(), lookup_breakpoint(x_value));
        end
      end
      if (cfg_valid && cfg_ready) begin
        cfg_taken++;
        bp_count = cfg_data;
      end
      if (busy || result_valid || item_now || pending_lookups.size() != 0) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  initial begin : stimulus
    logic signed [31:0] tbl_x [TableDepth];
    logic signed [31:0] key, qx;
    int cnt, phase, n_eff, n_evals, style, i, j, k, sel;

    // single point: exact, below, above
    push_load(0, 32'sd0, 32'sh7FFF_FFFF);
    push_eval(32'sd0);
    push_eval(32'sh8000_0000);
    push_eval(32'sh7FFF_FFFF);
    // a count of zero behaves as one
    push_cfg(0);
    push_eval(32'sd1);
    // top slot, full-range bracket with the widest product
    push_load(TableDepth - 1, -32'sd1, -32'sd1);
    push_load(1, 32'sh7FFF_FFFF, 32'sh8000_0000);
    push_load(0, 32'sh8000_0000, 32'sh7FFF_FFFF);
    push_cfg(2);
    push_eval(32'sd0);
    push_eval(32'sh8000_0000);
    push_eval(32'sh7FFF_FFFF);
    push_eval(32'sh8000_0001);
    push_eval(32'sh7FFF_FFFE);
    // duplicate x: lower bound takes the first
    push_load(0, 32'sd100, 32'sd5);
    push_load(1, 32'sd100, 32'sd9);
    push_load(2, 32'sd200, -32'sd7);
    push_cfg(3);
    push_eval(32'sd100);
    push_eval(32'sd150);
    push_eval(32'sd50);
    // unordered table
    push_load(0, 32'sd500, -32'sd40000);
    push_load(1, 32'sd100, 32'sd70000);
    push_load(2, 32'sd300, 32'sd3);
    push_eval(32'sd200);
    push_eval(32'sd400);
    push_eval(32'sd600);

    phase = 0;
    while (item_count < TOTAL_ITEMS) begin
      case (phase)
        0: cnt = 64;
        1: cnt = 127;
        2: cnt = 65;
        default: begin
          sel = $urandom_range(0, 19);
          if (sel < 2) cnt = $urandom_range(0, 1);
          else if (sel < 4) cnt = $urandom_range(64, 127);
          else if (sel < 7) cnt = $urandom_range(17, 63);
          else cnt = $urandom_range(2, 16);
        end
      endcase
      push_cfg(cnt);
      n_eff = cnt;
      if (n_eff < 1) n_eff = 1;
      if (n_eff > TableDepth) n_eff = TableDepth;

      style = $urandom_range(0, 9);
      if (style <= 5) begin
        for (i = 0; i < n_eff; i++) tbl_x[i] = $urandom();
        for (i = 1; i < n_eff; i++) begin
          key = tbl_x[i];
          j = i - 1;
          while (j >= 0 && tbl_x[j] > key) begin
            tbl_x[j+1] = tbl_x[j];
            j--;
          end
          tbl_x[j+1] = key;
        end
      end else if (style <= 8) begin
        // tight cluster with repeated x values
        tbl_x[0] = rand_between(-64'sd2147483648, 64'sd2147483647 - 64 * 4096);
        for (i = 1; i < n_eff; i++)
          tbl_x[i] = tbl_x[i-1] +
                     (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4096));
      end else begin
        for (i = 0; i < n_eff; i++) tbl_x[i] = $urandom();
      end
      for (i = 0; i < n_eff; i++)
        push_load(i, tbl_x[i],
                  ($urandom_range(0, 9) < 7) ? $signed($urandom())
                                             : rand_between(-32768, 32767));
      if (n_eff < TableDepth && $urandom_range(0, 2) == 0)
        push_load($urandom_range(n_eff, TableDepth - 1), $urandom(), $urandom());

      n_evals = $urandom_range(20, 60);
      for (k = 0; k < n_evals; k++) begin
        if ($urandom_range(0, 19) == 0) begin
          push_load($urandom_range(0, TableDepth - 1), $urandom(), $urandom());
        end else begin
          sel = $urandom_range(0, 19);
          if (sel < 5 || (sel < 13 && n_eff == 1)) begin
            qx = gen_x[$urandom_range(0, n_eff - 1)];
          end else if (sel < 13) begin
            i = $urandom_range(1, n_eff - 1);
            qx = rand_between(longint'(gen_x[i-1]) + 1, gen_x[i]);
          end else if (sel < 15) begin
            qx = rand_between(-64'sd2147483648, longint'(gen_x[0]) - 1);
          end else if (sel < 17) begin
            qx = rand_between(longint'(gen_x[n_eff-1]) + 1, 64'sd2147483647);
          end else if (sel == 17) begin
            qx = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
          end else begin
            qx = $urandom();
          end
          push_eval(qx);
        end
      end
      phase++;
    end

    while (cmd_queue.size() != 0 || drive_state != DRIVE_IDLE) @(posedge clk);
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/plwe_pkg.sv
hw/rtl/plwe_divider.sv
hw/rtl/plwe_datapath.sv
hw/rtl/plwe_ctrl.sv
hw/rtl/piecewise_linear_evaluator_unit.sv
dv/piecewise_linear_evaluator_unit_test.sv
